@@ rtl/msc_pkg.sv @@
// Shared types and constants for the MIPS subset core step block.
// Used by msc_regfile, msc_exec and mips_subset_core_step_top; no dependencies.
package msc_pkg;

    localparam int unsigned REG_COUNT_DEF = 32;
    localparam int unsigned REG_IDX_W     = 5;
    localparam logic [31:0] BOOT_RESET    = 32'hbfc0_0000;
    localparam logic [31:0] PC_STEP       = 32'd4;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;

    localparam logic KIND_EXEC = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] instruction;
        logic [31:0] load_data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] instr_pc;
        logic        mem_enable;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [31:0] mem_wdata;
        logic        awaiting_load;
    } out_item_t;

    // register file write-back
    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] addr;
        logic [31:0]          data;
    } wb_t;

    // architectural state update from the execute stage
    typedef struct packed {
        logic                 pc_advance;
        logic                 pend;
        logic [REG_IDX_W-1:0] dest;
    } upd_t;

endpackage

@@ rtl/msc_regfile.sv @@
// General register file: two registered read ports, one write port, per-entry valid bits.
// Depends on msc_pkg (wb_t, REG_IDX_W).
module msc_regfile
    import msc_pkg::*;
#(
    parameter int unsigned REG_COUNT = REG_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [REG_IDX_W-1:0] ra_addr,
    input  logic [REG_IDX_W-1:0] rb_addr,
    input  wb_t                  wb,
    output logic [31:0]          ra_data,
    output logic [31:0]          rb_data
);

    localparam int unsigned AW = $clog2(REG_COUNT);

    logic [31:0]          mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [31:0]          ra_reg;
    logic [31:0]          rb_reg;

    always_ff @(posedge clk)
    begin
        if (wb.we)
        begin
            mem[wb.addr[AW-1:0]] <= wb.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wb.we)
        begin
            valid_reg[wb.addr[AW-1:0]] <= 1'b1;
        end
    end

    // write-first: a write in the same cycle is passed straight to the read register
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wb.we && wb.addr == ra_addr)
                ra_reg <= wb.data;
            else if (valid_reg[ra_addr[AW-1:0]])
                ra_reg <= mem[ra_addr[AW-1:0]];
            else
                ra_reg <= '0;

            if (wb.we && wb.addr == rb_addr)
                rb_reg <= wb.data;
            else if (valid_reg[rb_addr[AW-1:0]])
                rb_reg <= mem[rb_addr[AW-1:0]];
            else
                rb_reg <= '0;
        end
    end

    assign ra_data = ra_reg;
    assign rb_data = rb_reg;

endmodule

@@ rtl/msc_exec.sv @@
// Execute logic: decode, shared adder, write-back and result formation for one item.
// Depends on msc_pkg (item structs, opcodes, wb_t, upd_t).
module msc_exec
    import msc_pkg::*;
(
    input  in_item_t             item,
    input  logic [31:0]          rs_val,
    input  logic [31:0]          rt_val,
    input  logic [31:0]          pc,
    input  logic                 pend,
    input  logic [REG_IDX_W-1:0] dest,
    output out_item_t            result,
    output logic                 result_valid,
    output wb_t                  wb,
    output upd_t                 upd
);

    logic [5:0]           op;
    logic [5:0]           fn;
    logic [REG_IDX_W-1:0] rt;
    logic [REG_IDX_W-1:0] rd;
    logic [31:0]          imm_se;
    logic [31:0]          sum;

    assign op     = item.instruction[31:26];
    assign fn     = item.instruction[5:0];
    assign rt     = item.instruction[20:16];
    assign rd     = item.instruction[15:11];
    assign imm_se = {{16{item.instruction[15]}}, item.instruction[15:0]};
    assign sum    = rs_val + ((op == OP_SPECIAL) ? rt_val : imm_se);

    always_comb
    begin
        result          = '0;
        result.instr_pc = pc;
        result_valid    = 1'b0;
        wb              = '0;
        upd.pc_advance  = 1'b0;
        upd.pend        = pend;
        upd.dest        = dest;

        if (item.kind == KIND_LOAD)
        begin
            if (pend)
            begin
                wb.we    = (dest != '0);
                wb.addr  = dest;
                wb.data  = item.load_data;
                upd.pend = 1'b0;
            end
        end
        else
        begin
            result_valid   = 1'b1;
            upd.pc_advance = 1'b1;
            upd.pend       = 1'b0;
            unique case (op)
                OP_SPECIAL:
                begin
                    wb.we   = (rd != '0);
                    wb.addr = rd;
                    wb.data = (fn == FN_ADD || fn == FN_ADDU) ? sum : '0;
                end
                OP_ADDIU:
                begin
                    wb.we   = (rt != '0);
                    wb.addr = rt;
                    wb.data = sum;
                end
                OP_LUI:
                begin
                    wb.we   = (rt != '0);
                    wb.addr = rt;
                    wb.data = {item.instruction[15:0], 16'h0000};
                end
                OP_LW:
                begin
                    result.mem_enable    = 1'b1;
                    result.mem_address   = sum;
                    result.awaiting_load = 1'b1;
                    upd.pend             = 1'b1;
                    upd.dest             = rt;
                end
                OP_SW:
                begin
                    result.mem_enable  = 1'b1;
                    result.mem_write   = 1'b1;
                    result.mem_address = sum;
                    result.mem_wdata   = rt_val;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ rtl/mips_subset_core_step_top.sv @@
// Top level of the MIPS subset core step block: input stage, execute stage, result register.
// Depends on msc_pkg, msc_regfile and msc_exec.
//
// Usage:
//   in_valid/in_ready/in_data carry instruction and load-return items (kind 0 / 1).
//   out_valid/out_ready/out_data carry one result per instruction: its PC and the
//   data-bus request. Load-return items give no result.
//   cfg_valid/cfg_ready/cfg_data write a new start address into the PC;
//   cfg_ready is always high and writes are expected only while the block is idle.
// Timing:
//   An item is registered on acceptance while its source registers are read; it
//   executes in the following cycle and its result then enters the output register
//   unless the output is stalled. One item per cycle is sustained while the output
//   is not stalled, set by the single execute stage; register results are forwarded,
//   so dependent instructions follow back to back.
// Reset:
//   rst_n clears all general registers (valid bits), the pending load, and loads the
//   PC with 0xbfc00000. There is no clearing pass.
// Stall:
//   A held result keeps the output register; a following instruction waits in the
//   execute stage and in_ready drops only when that stage cannot drain. Load-return
//   items still drain from the execute stage while the output is stalled.
module mips_subset_core_step_top
    import msc_pkg::*;
#(
    parameter int unsigned REG_COUNT = REG_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic                 ex_valid_reg;
    logic                 ex_valid_next;
    in_item_t             ex_item_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_item_t            out_data_reg;
    logic [31:0]          pc_reg;
    logic [31:0]          pc_next;
    logic                 pend_reg;
    logic                 pend_next;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [REG_IDX_W-1:0] dest_next;

    logic        in_accept;
    logic        ex_fire;
    logic        cfg_write;
    logic [31:0] rs_val;
    logic [31:0] rt_val;
    out_item_t   ex_result;
    logic        ex_result_valid;
    wb_t         ex_wb;
    wb_t         rf_wb;
    upd_t        ex_upd;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // a load return needs no output slot, an instruction does
    assign ex_fire   = ex_valid_reg &&
                       (ex_item_reg.kind == KIND_LOAD || !out_valid_reg || out_ready);
    assign in_ready  = !ex_valid_reg || ex_fire;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        rf_wb    = ex_wb;
        rf_wb.we = ex_wb.we && ex_fire;
    end

    msc_regfile #(
        .REG_COUNT(REG_COUNT)
    ) u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (in_accept),
        .ra_addr(in_data.instruction[25:21]),
        .rb_addr(in_data.instruction[20:16]),
        .wb     (rf_wb),
        .ra_data(rs_val),
        .rb_data(rt_val)
    );

    msc_exec u_exec (
        .item        (ex_item_reg),
        .rs_val      (rs_val),
        .rt_val      (rt_val),
        .pc          (pc_reg),
        .pend        (pend_reg),
        .dest        (dest_reg),
        .result      (ex_result),
        .result_valid(ex_result_valid),
        .wb          (ex_wb),
        .upd         (ex_upd)
    );

    always_comb
    begin
        ex_valid_next  = in_accept ? 1'b1 : (ex_fire ? 1'b0 : ex_valid_reg);
        out_valid_next = (ex_fire && ex_result_valid) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_reg);
        pc_next   = pc_reg;
        pend_next = pend_reg;
        dest_next = dest_reg;
        priority if (cfg_write)
        begin
            pc_next = cfg_data;
        end
        else if (ex_fire)
        begin
            pc_next   = ex_upd.pc_advance ? pc_reg + PC_STEP : pc_reg;
            pend_next = ex_upd.pend;
            dest_next = ex_upd.dest;
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= BOOT_RESET;
            pend_reg      <= 1'b0;
            dest_reg      <= '0;
        end
        else
        begin
            ex_valid_reg  <= ex_valid_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
            pend_reg      <= pend_next;
            dest_reg      <= dest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            ex_item_reg <= in_data;
        if (ex_fire && ex_result_valid)
            out_data_reg <= ex_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_wb.we |-> rf_wb.addr != '0)
        else $error("write-back to register zero enabled");

    a_await_is_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.awaiting_load |->
            out_data_reg.mem_enable && !out_data_reg.mem_write)
        else $error("awaiting_load set on a result that is not a load");

    a_lw_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ex_fire && ex_item_reg.kind == KIND_EXEC &&
        ex_item_reg.instruction[31:26] == OP_LW && !cfg_write |=> pend_reg)
        else $error("load did not leave a pending load");

    a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
        ex_fire && ex_item_reg.kind == KIND_EXEC && !cfg_write |=>
            pc_reg == $past(pc_reg) + PC_STEP)
        else $error("program counter did not advance by one instruction");

endmodule

@@ tb/sv/msc_step_checker.sv @@
// Checker for mips_subset_core_step_top: tracks the core's architectural state,
// predicts the bus request of each instruction and compares it with each result.
// Depends on msc_pkg for the channel types, opcodes and reset constants.
module msc_step_checker
    import msc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int unsigned fail_count,
    output int unsigned pending_results
);

    localparam int unsigned PRINT_LIMIT = 60;

    logic [31:0]          gpr [REG_COUNT_DEF];
    logic [31:0]          fetch_pc;
    logic                 load_wait;
    logic [REG_IDX_W-1:0] load_reg;
    out_item_t            bus_requests_q [$];

    initial fail_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // register 0 is hard-wired to zero, so writes to it are simply dropped
    task automatic write_gpr(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        if (idx != '0)
            gpr[idx] = val;
    endtask

    task automatic step_core(input in_item_t it, output bit has_res, output out_item_t res);
        logic [5:0]           op;
        logic [5:0]           fn;
        logic [REG_IDX_W-1:0] rs;
        logic [REG_IDX_W-1:0] rt;
        logic [REG_IDX_W-1:0] rd;
        logic [31:0]          imm;
        logic [31:0]          a;
        logic [31:0]          b;
        res     = '0;
        has_res = 1'b0;
        if (it.kind == KIND_LOAD)
        begin
            // a load return with nothing outstanding is dropped
            if (load_wait)
            begin
                write_gpr(load_reg, it.load_data);
                load_wait = 1'b0;
            end
        end
        else
        begin
            has_res   = 1'b1;
            load_wait = 1'b0;        // any instruction cancels an outstanding load
            res.instr_pc = fetch_pc;
            fetch_pc     = fetch_pc + PC_STEP;
            op  = it.instruction[31:26];
            rs  = it.instruction[25:21];
            rt  = it.instruction[20:16];
            rd  = it.instruction[15:11];
            fn  = it.instruction[5:0];
            imm = {{16{it.instruction[15]}}, it.instruction[15:0]};
            a   = gpr[rs];
            b   = gpr[rt];
            if (op == OP_SPECIAL)
            begin
                if (fn == FN_ADD || fn == FN_ADDU)
                    write_gpr(rd, a + b);
                else
                    write_gpr(rd, 32'd0);
            end
            else if (op == OP_ADDIU)
                write_gpr(rt, a + imm);
            else if (op == OP_LUI)
                write_gpr(rt, {it.instruction[15:0], 16'h0000});
            else if (op == OP_LW)
            begin
                res.mem_enable    = 1'b1;
                res.mem_address   = a + imm;
                res.awaiting_load = 1'b1;
                load_wait         = 1'b1;
                load_reg          = rt;
            end
            else if (op == OP_SW)
            begin
                res.mem_enable  = 1'b1;
                res.mem_write   = 1'b1;
                res.mem_address = a + imm;
                res.mem_wdata   = b;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        bit        has_res;
        out_item_t res;
        out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT_DEF; i++)
                gpr[i] = '0;
            fetch_pc  = BOOT_RESET;
            load_wait = 1'b0;
            load_reg  = '0;
            bus_requests_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (bus_requests_q.size() == 0)
                    report_mismatch("unexpected result, pc", out_data.instr_pc, 32'd0);
                else
                begin
                    want = bus_requests_q.pop_front();
                    check_field("instr_pc", out_data.instr_pc, want.instr_pc);
                    check_field("mem_enable", 32'(out_data.mem_enable),
                                32'(want.mem_enable));
                    check_field("mem_write", 32'(out_data.mem_write),
                                32'(want.mem_write));
                    check_field("mem_address", out_data.mem_address, want.mem_address);
                    check_field("mem_wdata", out_data.mem_wdata, want.mem_wdata);
                    check_field("awaiting_load", 32'(out_data.awaiting_load),
                                32'(want.awaiting_load));
                end
            end
            // a boot address write reloads the fetch address
            if (cfg_valid && cfg_ready)
                fetch_pc = cfg_data;
            if (in_valid && in_ready)
            begin
                step_core(in_data, has_res, res);
                if (has_res)
                    bus_requests_q.push_back(res);
            end
        end
        pending_results <= bus_requests_q.size();
    end

endmodule

@@ tb/sv/tb_mips_subset_core_step_top.sv @@
// Testbench top for mips_subset_core_step_top: drives instruction and load-return
// transactions and boot address writes, and gives the verdict.
// Depends on msc_pkg, the block and msc_step_checker.
module tb_mips_subset_core_step_top;
    import msc_pkg::*;

    localparam int unsigned STALL_PCT    = 18;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam logic [5:0]  FN_SUB       = 6'h22;   // not implemented: writes zero
    localparam logic [5:0]  OP_UNIMPL    = 6'h3f;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    int unsigned fail_count;
    int unsigned pending_results;
    int unsigned idle_cycles;
    bit          gaps_on;

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    mips_subset_core_step_top #(
        .REG_COUNT (REG_COUNT_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    msc_step_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !gaps_on || ($urandom_range(99) >= STALL_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles == IDLE_LIMIT)
            begin
                $display("mips_subset_core_step_top regression: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] r_type(input logic [4:0] rs, input logic [4:0] rt,
                                           input logic [4:0] rd, input logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic logic [31:0] i_type(input logic [5:0] op, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // bias towards a few registers so that results feed later instructions
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(99) < 60)
            return 5'($urandom_range(7));
        return 5'($urandom_range(31));
    endfunction

    function automatic logic [31:0] rand_word();
        unique case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // valid is only lowered for an idle cycle, never between back-to-back transactions
    task automatic push_item(input in_item_t it);
        if (gaps_on)
            while ($urandom_range(99) < STALL_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_exec(input logic [31:0] word);
        in_item_t it;
        it.kind        = KIND_EXEC;
        it.instruction = word;
        it.load_data   = $urandom();
        push_item(it);
    endtask

    task automatic send_load(input logic [31:0] data);
        in_item_t it;
        it.kind        = KIND_LOAD;
        it.instruction = $urandom();
        it.load_data   = data;
        push_item(it);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        // a trailing load return leaves no result behind, so allow it to settle
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_boot(input logic [31:0] addr);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_items();
        send_exec(i_type(OP_LUI, 5'd0, 5'd1, 16'hffff));
        send_exec(i_type(OP_ADDIU, 5'd0, 5'd2, 16'h7fff));
        send_exec(i_type(OP_ADDIU, 5'd1, 5'd3, 16'h8000));
        send_exec(r_type(5'd1, 5'd2, 5'd4, FN_ADD));
        send_exec(r_type(5'd4, 5'd3, 5'd5, FN_ADDU));
        send_exec(r_type(5'd1, 5'd2, 5'd5, FN_SUB));
        send_exec(i_type(OP_ADDIU, 5'd1, 5'd0, 16'h0001));   // write to r0 dropped
        send_exec(i_type(OP_SW, 5'd5, 5'd0, 16'h0000));
        send_exec(i_type(OP_LW, 5'd1, 5'd6, 16'hfffc));
        send_load(32'hffff_ffff);
        send_exec(i_type(OP_LW, 5'd2, 5'd0, 16'h0000));
        send_load(32'hdead_beef);                           // load into r0 dropped
        send_exec(r_type(5'd0, 5'd6, 5'd7, FN_ADDU));
        send_exec(i_type(OP_SW, 5'd2, 5'd6, 16'h7fff));
        send_exec(i_type(OP_LW, 5'd0, 5'd7, 16'h8000));
        send_exec(r_type(5'd7, 5'd7, 5'd8, FN_ADD));         // cancels the load
        send_load(32'h1234_5678);
        send_load(32'ha5a5_a5a5);                           // nothing outstanding
        send_exec(32'hffff_ffff);
        send_exec(32'h0000_0000);
        send_exec(i_type(OP_UNIMPL, 5'd1, 5'd2, 16'h1234));
        send_exec(i_type(OP_SW, 5'd8, 5'd7, 16'h0000));
    endtask

    task automatic random_items(input int unsigned n);
        int unsigned pick;
        int unsigned tail;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        for (int unsigned i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            rs   = pick_reg();
            rt   = pick_reg();
            rd   = pick_reg();
            if (pick < 18)
                send_exec(r_type(rs, rt, rd, $urandom_range(1) ? FN_ADD : FN_ADDU));
            else if (pick < 36)
                send_exec(i_type(OP_ADDIU, rs, rt, 16'($urandom())));
            else if (pick < 44)
                send_exec(i_type(OP_LUI, rs, rt, 16'($urandom())));
            else if (pick < 66)
            begin
                send_exec(i_type(OP_LW, rs, rt, 16'($urandom())));
                tail = $urandom_range(9);
                if (tail < 7)
                    send_load(rand_word());
                else if (tail < 9)
                begin
                    // another instruction slips in first: the return is then stale
                    send_exec(r_type(pick_reg(), pick_reg(), pick_reg(), FN_ADDU));
                    send_load(rand_word());
                end
            end
            else if (pick < 82)
                send_exec(i_type(OP_SW, rs, rt, 16'($urandom())));
            else if (pick < 88)
            begin
                fn = 6'($urandom_range(63));
                if (fn == FN_ADD || fn == FN_ADDU)
                    fn = FN_SUB;
                send_exec({OP_SPECIAL, rs, rt, rd, 5'($urandom()), fn});
            end
            else if (pick < 94)
                send_exec({6'($urandom_range(63)), 26'($urandom())});
            else if (pick < 97)
                send_exec($urandom());
            else
                send_load(rand_word());
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        gaps_on   = 1'b1;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        random_items(40);
        write_boot(32'h0000_0000);
        random_items(100);
        // hold off the sender until every outstanding result is back
        wait_results_drained();
        random_items(50);
        write_boot(32'hffff_fff8);          // PC wraps after two instructions
        gaps_on <= 1'b0;
        random_items(110);
        gaps_on <= 1'b1;
        write_boot(32'hffff_ffff);
        random_items(80);
        write_boot($urandom());
        random_items(80);
        write_boot(BOOT_RESET);
        random_items(45);

        wait_results_drained();
        if (fail_count == 0)
            $display("mips_subset_core_step_top regression: pass");
        else
            $display("mips_subset_core_step_top regression: fail");
        $finish;
    end

endmodule
